// ----- rtl/heading_odometry_tracker_top_macros.svh -----
// Assertion shorthands for the odometry tracker, clocked on aclk, off during reset.
`ifndef HEADING_ODOMETRY_TRACKER_TOP_MACROS_SVH
`define HEADING_ODOMETRY_TRACKER_TOP_MACROS_SVH

// Same-cycle implication
`define HOT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define HOT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hot_pkg.sv -----
`default_nettype none

package hot_pkg;

    // Beat widths
    localparam int IN_W      = 80;
    localparam int OUT_W     = 96;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;
    localparam int PC_W      = 4;

    localparam int CORDIC_ITERS_DEF = 16;

    // Register indexes on the config channel
    localparam logic [CFG_IDX_W-1:0] REG_START_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIST      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_REV  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_REV = 3'd4;

    // Register reset values
    localparam logic [31:0] START_X_RST = 32'h0006_0000;   //  6.0 in
    localparam logic [31:0] START_Y_RST = 32'hFFF6_8000;   // -9.5 in
    localparam logic [23:0] DIST_RST    = 24'd1573;

    // Angle and CORDIC constants, Q30
    localparam logic [31:0]        PI_Q30   = 32'd3373259426;
    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

    // Datapath operations, one per control word
    typedef enum logic [3:0] {
        OP_WAIT,
        OP_TEST,
        OP_SUM,
        OP_MULSTEP,
        OP_SAT,
        OP_ANGLE,
        OP_ZINIT,
        OP_ROT,
        OP_FLIP,
        OP_MULX,
        OP_ADDX,
        OP_MULY,
        OP_ADDY,
        OP_INIT,
        OP_OUT
    } hot_op_t;

    // Sequencer jump conditions
    typedef enum logic [1:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_NOBASE,
        COND_LOOP
    } hot_cond_t;

    typedef struct packed {
        hot_op_t          op;
        hot_cond_t        cond;
        logic [PC_W-1:0]  target;
    } hot_uword_t;

    // Program step addresses
    localparam logic [PC_W-1:0] PC_WAIT = 4'd0;
    localparam logic [PC_W-1:0] PC_TEST = 4'd1;
    localparam logic [PC_W-1:0] PC_ROT  = 4'd7;
    localparam logic [PC_W-1:0] PC_INIT = 4'd13;
    localparam logic [PC_W-1:0] PC_OUT  = 4'd14;

    // Control store
    function automatic hot_uword_t ucode(input logic [PC_W-1:0] pc);
        hot_uword_t w;
        unique case (pc)
            4'd0:    w = '{OP_WAIT,    COND_NEXT,   PC_WAIT};
            4'd1:    w = '{OP_TEST,    COND_NOBASE, PC_INIT};
            4'd2:    w = '{OP_SUM,     COND_NEXT,   PC_WAIT};
            4'd3:    w = '{OP_MULSTEP, COND_NEXT,   PC_WAIT};
            4'd4:    w = '{OP_SAT,     COND_NEXT,   PC_WAIT};
            4'd5:    w = '{OP_ANGLE,   COND_NEXT,   PC_WAIT};
            4'd6:    w = '{OP_ZINIT,   COND_NEXT,   PC_WAIT};
            4'd7:    w = '{OP_ROT,     COND_LOOP,   PC_ROT};
            4'd8:    w = '{OP_FLIP,    COND_NEXT,   PC_WAIT};
            4'd9:    w = '{OP_MULX,    COND_NEXT,   PC_WAIT};
            4'd10:   w = '{OP_ADDX,    COND_NEXT,   PC_WAIT};
            4'd11:   w = '{OP_MULY,    COND_NEXT,   PC_WAIT};
            4'd12:   w = '{OP_ADDY,    COND_ALWAYS, PC_OUT};
            4'd13:   w = '{OP_INIT,    COND_NEXT,   PC_WAIT};
            4'd14:   w = '{OP_OUT,     COND_ALWAYS, PC_WAIT};
            default: w = '{OP_WAIT,    COND_ALWAYS, PC_WAIT};
        endcase
        return w;
    endfunction

    // atan(2^-i) in Q30, rounded; past i = 9 the series is 2^(30-i)
    function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
        logic signed [33:0] v;
        unique case (idx)
            5'd0:    v = 34'sd843314856;
            5'd1:    v = 34'sd497837829;
            5'd2:    v = 34'sd263043837;
            5'd3:    v = 34'sd133525159;
            5'd4:    v = 34'sd67021687;
            5'd5:    v = 34'sd33543516;
            5'd6:    v = 34'sd16775851;
            5'd7:    v = 34'sd8388437;
            5'd8:    v = 34'sd4194283;
            5'd9:    v = 34'sd2097149;
            default: v = 34'sd1 <<< (5'd30 - idx);
        endcase
        return v;
    endfunction

    // Q16.16 to whole inches, half away from zero, low 16 bits
    function automatic logic [15:0] round_inch(input logic [31:0] p);
        logic [32:0] mag;
        logic [32:0] q;
        mag = p[31] ? (33'd0 - {1'b1, p}) : {1'b0, p};
        q   = (mag + 33'd32768) >> 16;
        return p[31] ? (16'd0 - q[15:0]) : q[15:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/heading_odometry_tracker_top.sv -----
// Each accepted sample runs the whole microprogram before the next is taken; the baseline sample
// goes from the test step through init to output. Throughput, while no result is blocked, is set by the
// one-iteration-per-cycle CORDIC loop of the microprogram and the shared multiplier.
// The next sample is taken while a result beat still waits on m_tready.
// Reset (aresetn low, synchronous) restores the registers, drops the baseline and
// returns the sequencer to its wait step; m_tvalid goes low.
`default_nettype none

module heading_odometry_tracker_top #(
    parameter int CORDIC_ITERS = hot_pkg::CORDIC_ITERS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // heading_angle[15:0], left_count[47:16], right_count[79:48]
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    input  wire logic [hot_pkg::IN_W-1:0]       s_tdata,
    // pos_x[31:0], pos_y[63:32], round_x[79:64], round_y[95:80]
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    output      logic [hot_pkg::OUT_W-1:0]      m_tdata,
    // register write channel
    input  wire logic                           cfg_valid,
    output      logic                           cfg_ready,
    input  wire logic [hot_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hot_pkg::CFG_W-1:0]      cfg_data
);

`include "heading_odometry_tracker_top_macros.svh"

    localparam int CNT_W = $clog2(CORDIC_ITERS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_ITERS - 1);
    localparam logic signed [67:0] HALF_Q30 = 68'sd536870912;

    // Sequencer
    logic [hot_pkg::PC_W-1:0] pc_reg, pc_next;
    hot_pkg::hot_uword_t      uw;
    logic                     out_free;

    // Config registers
    logic [31:0] start_x_reg, start_y_reg;
    logic [23:0] dist_reg;
    logic        lrev_reg, rrev_reg;

    // Tracker state
    logic        base_reg;
    logic [31:0] prev_l_reg, prev_r_reg;
    logic [31:0] cur_x_reg, cur_y_reg;

    // Working registers
    logic [15:0]         h_reg;
    logic [31:0]         l_reg, r_reg;
    logic signed [32:0]  sum_reg;
    logic signed [31:0]  step_reg;
    logic signed [67:0]  prod_reg;
    logic signed [33:0]  x_reg, y_reg, z_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                flip_reg, neg_reg;

    // Result beat
    logic                          m_valid_reg;
    logic [hot_pkg::OUT_W-1:0]     m_data_reg;

    // Datapath helpers
    logic [31:0]         l_in, r_in;
    logic [31:0]         dl, dr;
    logic signed [33:0]  mul_a, mul_b;
    logic signed [67:0]  mul_p;
    logic signed [67:0]  half_step;
    logic                sat_pos, sat_neg;
    logic                flip_c;
    logic [15:0]         hf;
    logic [16:0]         mag;
    logic signed [67:0]  zq;
    logic signed [33:0]  xs, ys, at;
    logic signed [67:0]  dpos;

    assign uw        = hot_pkg::ucode(pc_reg);
    assign s_tready  = (uw.op == hot_pkg::OP_WAIT);
    assign out_free  = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign cfg_ready = 1'b1;

    // Next step: hold on an empty input or a blocked result, else follow the word
    always_comb begin
        priority if (uw.op == hot_pkg::OP_WAIT && !s_tvalid) begin
            pc_next = pc_reg;
        end else if (uw.op == hot_pkg::OP_OUT && !out_free) begin
            pc_next = pc_reg;
        end else begin
            unique case (uw.cond)
                hot_pkg::COND_NEXT:   pc_next = pc_reg + 1'b1;
                hot_pkg::COND_ALWAYS: pc_next = uw.target;
                hot_pkg::COND_NOBASE: pc_next = base_reg ? pc_reg + 1'b1 : uw.target;
                hot_pkg::COND_LOOP:   pc_next = (cnt_reg != CNT_LAST) ? uw.target
                                                                      : pc_reg + 1'b1;
                default:              pc_next = hot_pkg::PC_WAIT;
            endcase
        end
    end

    // Input unpack with encoder reversal
    assign l_in = lrev_reg ? (32'd0 - s_tdata[47:16]) : s_tdata[47:16];
    assign r_in = rrev_reg ? (32'd0 - s_tdata[79:48]) : s_tdata[79:48];

    // Count deltas, modulo 2^32
    assign dl = l_reg - prev_l_reg;
    assign dr = r_reg - prev_r_reg;

    // Heading fold into [-90, 90] degrees
    always_comb begin
        flip_c = (h_reg > 16'd16384) && (h_reg < 16'd49152);
        hf     = flip_c ? (h_reg + 16'd32768) : h_reg;
        mag    = hf[15] ? (17'd65536 - {1'b0, hf}) : {1'b0, hf};
    end

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (uw.op)
            hot_pkg::OP_MULSTEP: begin
                mul_a = {sum_reg[32], sum_reg};
                mul_b = {10'd0, dist_reg};
            end
            hot_pkg::OP_ANGLE: begin
                mul_a = {17'd0, mag};
                mul_b = {2'd0, hot_pkg::PI_Q30};
            end
            hot_pkg::OP_MULX: begin
                mul_a = {{2{step_reg[31]}}, step_reg};
                mul_b = y_reg;
            end
            hot_pkg::OP_MULY: begin
                mul_a = {{2{step_reg[31]}}, step_reg};
                mul_b = x_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Step halving with round half up, then saturation
    always_comb begin
        half_step = (prod_reg + 68'sd1) >>> 1;
        sat_pos   = !half_step[67] && (|half_step[66:31]);
        sat_neg   = half_step[67] && !(&half_step[66:31]);
    end

    // Angle to Q30 radians, CORDIC shifts and table, position delta
    always_comb begin
        zq   = (prod_reg + 68'sd16384) >>> 15;
        xs   = x_reg >>> cnt_reg;
        ys   = y_reg >>> cnt_reg;
        at   = hot_pkg::atan_q30(5'(cnt_reg));
        dpos = (prod_reg + HALF_Q30) >>> 30;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= hot_pkg::PC_WAIT;
            base_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            start_x_reg <= hot_pkg::START_X_RST;
            start_y_reg <= hot_pkg::START_Y_RST;
            dist_reg    <= hot_pkg::DIST_RST;
            lrev_reg    <= 1'b0;
            rrev_reg    <= 1'b0;
            prev_l_reg  <= '0;
            prev_r_reg  <= '0;
        end else begin
            pc_reg <= pc_next;

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    hot_pkg::REG_START_X:   start_x_reg <= cfg_data;
                    hot_pkg::REG_START_Y:   start_y_reg <= cfg_data;
                    hot_pkg::REG_DIST:      dist_reg    <= cfg_data[23:0];
                    hot_pkg::REG_LEFT_REV:  lrev_reg    <= cfg_data[0];
                    hot_pkg::REG_RIGHT_REV: rrev_reg    <= cfg_data[0];
                    default: ;
                endcase
            end

            // baseline and encoder history
            if (uw.op == hot_pkg::OP_INIT) begin
                base_reg   <= 1'b1;
                prev_l_reg <= l_reg;
                prev_r_reg <= r_reg;
            end else if (uw.op == hot_pkg::OP_SAT) begin
                prev_l_reg <= l_reg;
                prev_r_reg <= r_reg;
            end

            // result beat
            if (uw.op == hot_pkg::OP_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath, one operation per control word
    always_ff @(posedge aclk) begin
        unique case (uw.op)
            hot_pkg::OP_WAIT: begin
                if (s_tvalid) begin
                    h_reg <= s_tdata[15:0];
                    l_reg <= l_in;
                    r_reg <= r_in;
                end
            end
            hot_pkg::OP_SUM: begin
                sum_reg <= {dl[31], dl} + {dr[31], dr};
            end
            hot_pkg::OP_MULSTEP, hot_pkg::OP_MULX, hot_pkg::OP_MULY: begin
                prod_reg <= mul_p;
            end
            hot_pkg::OP_SAT: begin
                priority if (sat_pos) begin
                    step_reg <= 32'sh7FFF_FFFF;
                end else if (sat_neg) begin
                    step_reg <= 32'sh8000_0000;
                end else begin
                    step_reg <= half_step[31:0];
                end
            end
            hot_pkg::OP_ANGLE: begin
                prod_reg <= mul_p;
                flip_reg <= flip_c;
                neg_reg  <= hf[15];
            end
            hot_pkg::OP_ZINIT: begin
                z_reg   <= neg_reg ? (34'sd0 - zq[33:0]) : zq[33:0];
                x_reg   <= hot_pkg::GAIN_Q30;
                y_reg   <= '0;
                cnt_reg <= '0;
            end
            hot_pkg::OP_ROT: begin
                if (!z_reg[33]) begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end else begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            hot_pkg::OP_FLIP: begin
                if (flip_reg) begin
                    x_reg <= 34'sd0 - x_reg;
                    y_reg <= 34'sd0 - y_reg;
                end
            end
            hot_pkg::OP_ADDX: begin
                cur_x_reg <= cur_x_reg + dpos[31:0];
            end
            hot_pkg::OP_ADDY: begin
                cur_y_reg <= cur_y_reg + dpos[31:0];
            end
            hot_pkg::OP_INIT: begin
                cur_x_reg <= start_x_reg;
                cur_y_reg <= start_y_reg;
            end
            hot_pkg::OP_OUT: begin
                if (out_free) begin
                    m_data_reg <= {hot_pkg::round_inch(cur_y_reg),
                                   hot_pkg::round_inch(cur_x_reg),
                                   cur_y_reg, cur_x_reg};
                end
            end
            default: ;
        endcase
    end

    // Checks
    `HOT_ASSERT_NEXT(a_accept_to_test, s_tvalid && s_tready, pc_reg == hot_pkg::PC_TEST,
        "sample accepted but sequencer did not go to the baseline test")
    `HOT_ASSERT_NOW(a_rot_count, uw.op == hot_pkg::OP_ROT, cnt_reg <= CNT_LAST,
        "CORDIC iteration count out of range")
    `HOT_ASSERT_NEXT(a_out_hold, uw.op == hot_pkg::OP_OUT && m_valid_reg && !m_tready,
        pc_reg == hot_pkg::PC_OUT,
        "sequencer left the output step while a result beat was blocked")
    `HOT_ASSERT_NEXT(a_base_sticky, base_reg, base_reg,
        "baseline dropped without reset")
    `HOT_ASSERT_NEXT(a_init_to_out, uw.op == hot_pkg::OP_INIT,
        base_reg && pc_reg == hot_pkg::PC_OUT,
        "baseline sample did not go straight to the output step")

endmodule

`default_nettype wire
